// ===== hdl/sbtr_pkg.sv =====
`default_nettype none

package sbtr_pkg;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int COL_W   = 32;
	localparam int CODE_W  = 7;
	localparam int KIND_W  = 2;
	localparam int MASK_W  = 64;
	localparam int SPAN_W  = 7;
	localparam int SCALE_W = 4;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// default geometry
	localparam int DEF_GLYPH_W        = 8;
	localparam int DEF_GLYPH_H        = 8;
	localparam int DEF_GLYPHS_PER_ROW = 16;
	localparam int DEF_NUM_GLYPHS     = 128;
	localparam int DEF_MAX_SCALE      = 8;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd2;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 7'd10;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_SCALE = 2'd0;
	localparam logic [1:0] REG_FG    = 2'd1;
	localparam logic [1:0] REG_MATCH = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
	localparam logic [COL_W-1:0]   COL_RST   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIX_FIX,
		ST_PIX_WRITE,
		ST_CHAR_EMIT
	} state_t;

	typedef struct packed {
		logic pix_start;
		logic pix_fix;
		logic pix_write;
		logic set_start;
		logic newline;
		logic char_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_row;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/sbtr_regs.sv =====
`default_nettype none

module sbtr_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [sbtr_pkg::PADDR_W-1:0]   paddr,
	input  wire  [sbtr_pkg::PDATA_W-1:0]   pwdata,
	output logic [sbtr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [sbtr_pkg::SCALE_W-1:0]   scale,
	output logic [sbtr_pkg::COL_W-1:0]     fg_colour,
	output logic [sbtr_pkg::COL_W-1:0]     match_colour
);

	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale        <= sbtr_pkg::SCALE_RST;
			fg_colour    <= sbtr_pkg::COL_RST;
			match_colour <= sbtr_pkg::COL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sbtr_pkg::REG_SCALE: scale        <= pwdata[sbtr_pkg::SCALE_W-1:0];
				sbtr_pkg::REG_FG:    fg_colour    <= pwdata;
				sbtr_pkg::REG_MATCH: match_colour <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sbtr_pkg::REG_SCALE: prdata = {{(sbtr_pkg::PDATA_W-sbtr_pkg::SCALE_W){1'b0}}, scale};
			sbtr_pkg::REG_FG:    prdata = fg_colour;
			sbtr_pkg::REG_MATCH: prdata = match_colour;
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/sbtr_ctrl.sv =====
`default_nettype none

module sbtr_ctrl (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [sbtr_pkg::KIND_W-1:0]    kind,
	input  wire  [sbtr_pkg::CODE_W-1:0]    char_code,
	input  wire  sbtr_pkg::stat_t          stat,
	output sbtr_pkg::cmd_t                 cmd
);

	sbtr_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			sbtr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (kind)
						sbtr_pkg::KIND_PIXEL: begin
							cmd.pix_start = 1'b1;
							state_nxt     = sbtr_pkg::ST_PIX_FIX;
						end
						sbtr_pkg::KIND_START: begin
							cmd.set_start = 1'b1;
						end
						sbtr_pkg::KIND_CHAR: begin
							if (char_code == sbtr_pkg::NEWLINE_CODE) begin
								cmd.newline = 1'b1;
							end else begin
								cmd.char_start = 1'b1;
								state_nxt      = sbtr_pkg::ST_CHAR_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			sbtr_pkg::ST_PIX_FIX: begin
				cmd.pix_fix = 1'b1;
				state_nxt   = sbtr_pkg::ST_PIX_WRITE;
			end
			sbtr_pkg::ST_PIX_WRITE: begin
				cmd.pix_write = 1'b1;
				state_nxt     = sbtr_pkg::ST_IDLE;
			end
			sbtr_pkg::ST_CHAR_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last_row) begin
						state_nxt = sbtr_pkg::ST_IDLE;
					end
				end
			end
			default: state_nxt = sbtr_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/sbtr_dp.sv =====
`default_nettype none

module sbtr_dp #(
	parameter int GLYPH_W        = sbtr_pkg::DEF_GLYPH_W,
	parameter int GLYPH_H        = sbtr_pkg::DEF_GLYPH_H,
	parameter int GLYPHS_PER_ROW = sbtr_pkg::DEF_GLYPHS_PER_ROW,
	parameter int NUM_GLYPHS     = sbtr_pkg::DEF_NUM_GLYPHS,
	parameter int MAX_SCALE      = sbtr_pkg::DEF_MAX_SCALE
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  sbtr_pkg::cmd_t           cmd,
	output sbtr_pkg::stat_t                stat,
	input  wire  [sbtr_pkg::COORD_W-1:0]   pos_x,
	input  wire  [sbtr_pkg::COORD_W-1:0]   pos_y,
	input  wire  [sbtr_pkg::CODE_W-1:0]    char_code,
	input  wire  [sbtr_pkg::COL_W-1:0]     pixel_colour,
	input  wire  [sbtr_pkg::SCALE_W-1:0]   scale,
	input  wire  [sbtr_pkg::COL_W-1:0]     fg_colour,
	input  wire  [sbtr_pkg::COL_W-1:0]     match_colour,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [sbtr_pkg::COORD_W-1:0]   row_x,
	output logic [sbtr_pkg::COORD_W-1:0]   row_y,
	output logic [sbtr_pkg::MASK_W-1:0]    fg_mask,
	output logic [sbtr_pkg::SPAN_W-1:0]    span,
	output logic [sbtr_pkg::COL_W-1:0]     colour,
	output logic                           last
);

	localparam int GLYPH_ROWS   = (NUM_GLYPHS + GLYPHS_PER_ROW - 1) / GLYPHS_PER_ROW;
	localparam int ATLAS_W      = GLYPHS_PER_ROW * GLYPH_W;
	localparam int ATLAS_H      = GLYPH_ROWS * GLYPH_H;
	localparam int ATLAS_GLYPHS = GLYPH_ROWS * GLYPHS_PER_ROW;
	localparam int GR_W         = $clog2(GLYPH_H);
	localparam int GI_W         = $clog2(ATLAS_GLYPHS);
	localparam int ADDR_W       = GI_W + GR_W;
	localparam int MEM_DEPTH    = 1 << ADDR_W;
	localparam int BIT_W        = $clog2(GLYPH_W);
	localparam int SC_W         = $clog2(MAX_SCALE + 1);
	localparam int ROW_W        = $clog2(GLYPH_H * MAX_SCALE);
	localparam int CW           = sbtr_pkg::COORD_W;
	localparam int MW           = sbtr_pkg::MASK_W;
	// floor(2^16 / n): quotient estimate is exact or one low for 16-bit inputs
	localparam logic [CW-1:0] RECIP_X = CW'((1 << CW) / GLYPH_W);
	localparam logic [CW-1:0] RECIP_Y = CW'((1 << CW) / GLYPH_H);

	// scale clamp
	logic [SC_W-1:0] s;
	always_comb begin
		if (scale == '0) begin
			s = SC_W'(1);
		end else if (32'(scale) > MAX_SCALE) begin
			s = SC_W'(MAX_SCALE);
		end else begin
			s = SC_W'(scale);
		end
	end

	logic [sbtr_pkg::SPAN_W-1:0] span_w;
	logic [ROW_W-1:0]            rows_m1;
	logic [CW-1:0]               nl_step;

	assign span_w  = sbtr_pkg::SPAN_W'(32'(GLYPH_W) * 32'(s));
	assign rows_m1 = ROW_W'(32'(GLYPH_H) * 32'(s) - 32'd1);
	assign nl_step = CW'((32'(3 * GLYPH_H) * 32'(s)) >> 1);

	// ---------------- atlas pixel write path ----------------
	logic [CW-1:0]    x_q, y_q, qxe_q, qye_q, qx_q, qy_q;
	logic             bit_q, range_q;
	logic [BIT_W-1:0] rx_q;
	logic [GR_W-1:0]  ry_q;
	logic [31:0]      prod_x, prod_y;
	logic [CW-1:0]    rxf, ryf;
	logic [GI_W-1:0]  wr_glyph;
	logic [ADDR_W-1:0] wr_addr;

	assign prod_x = {16'b0, pos_x} * {16'b0, RECIP_X};
	assign prod_y = {16'b0, pos_y} * {16'b0, RECIP_Y};
	assign rxf    = x_q - CW'(32'(qxe_q) * GLYPH_W);
	assign ryf    = y_q - CW'(32'(qye_q) * GLYPH_H);

	always_ff @(posedge clk) begin
		if (cmd.pix_start) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			bit_q   <= (pixel_colour == match_colour);
			range_q <= (32'(pos_x) < ATLAS_W) && (32'(pos_y) < ATLAS_H);
			qxe_q   <= prod_x[31:16];
			qye_q   <= prod_y[31:16];
		end
		if (cmd.pix_fix) begin
			if (32'(rxf) >= GLYPH_W) begin
				qx_q <= qxe_q + CW'(1);
				rx_q <= BIT_W'(32'(rxf) - GLYPH_W);
			end else begin
				qx_q <= qxe_q;
				rx_q <= BIT_W'(rxf);
			end
			if (32'(ryf) >= GLYPH_H) begin
				qy_q <= qye_q + CW'(1);
				ry_q <= GR_W'(32'(ryf) - GLYPH_H);
			end else begin
				qy_q <= qye_q;
				ry_q <= GR_W'(ryf);
			end
		end
	end

	assign wr_glyph = GI_W'(32'(qy_q) * GLYPHS_PER_ROW + 32'(qx_q));
	assign wr_addr  = {wr_glyph, ry_q};

	// ---------------- atlas memory: one glyph row per word ----------------
	logic [GLYPH_W-1:0] atlas_mem [MEM_DEPTH];
	logic [GLYPH_W-1:0] rdata_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;

	always_ff @(posedge clk) begin
		if (cmd.pix_write && range_q) begin
			atlas_mem[wr_addr][rx_q] <= bit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= atlas_mem[rd_addr];
		end
	end

	// ---------------- character row sequencing ----------------
	logic [GI_W-1:0]  glyph_q;
	logic             gvalid_q;
	logic [GR_W-1:0]  grow_q;
	logic [SC_W-1:0]  sub_q;
	logic [ROW_W-1:0] row_q;
	logic             sub_wrap;
	logic [GI_W-1:0]  glyph_live;

	assign glyph_live = GI_W'(32'(char_code));
	assign sub_wrap   = (sub_q == SC_W'(32'(s) - 32'd1));
	assign rd_en      = cmd.char_start || (cmd.emit && sub_wrap && !stat.last_row);
	assign rd_addr    = cmd.char_start ? {glyph_live, GR_W'(0)}
	                                   : {glyph_q, grow_q + GR_W'(1)};

	always_ff @(posedge clk) begin
		if (cmd.char_start) begin
			glyph_q  <= glyph_live;
			gvalid_q <= (32'(char_code) < NUM_GLYPHS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_q <= '0;
			sub_q  <= '0;
			row_q  <= '0;
		end else if (cmd.char_start) begin
			grow_q <= '0;
			sub_q  <= '0;
			row_q  <= '0;
		end else if (cmd.emit) begin
			row_q <= row_q + ROW_W'(1);
			if (sub_wrap) begin
				sub_q  <= '0;
				grow_q <= grow_q + GR_W'(1);
			end else begin
				sub_q <= sub_q + SC_W'(1);
			end
		end
	end

	// horizontal expansion, one variant per scale
	wire [MAX_SCALE:0][MW-1:0] exp_v;
	assign exp_v[0] = '0;
	for (genvar gk = 1; gk <= MAX_SCALE; gk++) begin : g_sc
		for (genvar gi = 0; gi < MW; gi++) begin : g_bit
			if (gi < GLYPH_W * gk) begin : g_on
				localparam int SRC_BIT = gi / gk;
				assign exp_v[gk][gi] = rdata_q[SRC_BIT];
			end else begin : g_off
				assign exp_v[gk][gi] = 1'b0;
			end
		end
	end

	// ---------------- cursor ----------------
	logic [CW-1:0] cursor_x_q, cursor_y_q, origin_x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			origin_x_q <= '0;
		end else if (cmd.set_start) begin
			cursor_x_q <= pos_x;
			cursor_y_q <= pos_y;
			origin_x_q <= pos_x;
		end else if (cmd.newline) begin
			cursor_x_q <= origin_x_q;
			cursor_y_q <= cursor_y_q + nl_step;
		end else if (cmd.emit && stat.last_row) begin
			cursor_x_q <= cursor_x_q + CW'(span_w);
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_x   <= cursor_x_q;
			row_y   <= cursor_y_q + CW'(row_q);
			fg_mask <= gvalid_q ? exp_v[s] : '0;
			span    <= span_w;
			colour  <= fg_colour;
			last    <= stat.last_row;
		end
	end

	assign stat.out_free = !out_valid || out_ready;
	assign stat.last_row = (row_q == rows_m1);

	// ---------------- checks ----------------
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("row loaded over an untaken row");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (row_q <= rows_m1))
		else $error("row counter ran past the glyph height");

	a_cursor_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.last_row) |=> (cursor_x_q == $past(cursor_x_q) + CW'($past(span_w))))
		else $error("cursor did not advance by the span");

	a_pix_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_write && range_q) |-> ((32'(rx_q) < GLYPH_W) && (32'(ry_q) < GLYPH_H)))
		else $error("atlas write offset outside the glyph cell");

endmodule

`default_nettype wire

// ===== hdl/scaled_bitmap_text_renderer.sv =====
// Scaled bitmap text renderer: a character generator over a loadable one-bit
// font atlas.
// Request channel (in_valid/in_ready): kind selects an atlas pixel write, a
// string start (sets cursor and line origin) or a character. A character
// request yields GLYPH_H*scale row results, each a foreground mask of
// GLYPH_W*scale pixels at (cursor x, cursor y + row), last on the final row.
// Newline (code 10) yields nothing; it moves the cursor to the next line.
// Result channel (out_valid/out_ready) is fed from an output register.
// Sequence: a start or newline request updates the cursor from the idle
// state; an atlas write steps through reciprocal divide, remainder fix and
// memory write. A character takes one atlas read, then one row per cycle
// while the receiver takes rows, set by the single registered read port of
// the atlas; the first row is loaded once its glyph row has been read.
// A stalled receiver holds the row sequencer; the next request is accepted
// while the last row still waits in the output register.
// Reset clears cursor, origin, handshake state and the registers (scale 1,
// colours all ones). The atlas is not cleared; glyphs must be written first.
// Registers over APB: 0x0 scale, 0x4 fg_colour, 0x8 match_colour.
`default_nettype none

module scaled_bitmap_text_renderer #(
	parameter int GLYPH_W        = sbtr_pkg::DEF_GLYPH_W,
	parameter int GLYPH_H        = sbtr_pkg::DEF_GLYPH_H,
	parameter int GLYPHS_PER_ROW = sbtr_pkg::DEF_GLYPHS_PER_ROW,
	parameter int NUM_GLYPHS     = sbtr_pkg::DEF_NUM_GLYPHS,
	parameter int MAX_SCALE      = sbtr_pkg::DEF_MAX_SCALE
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [sbtr_pkg::PADDR_W-1:0]   paddr,
	input  wire  [sbtr_pkg::PDATA_W-1:0]   pwdata,
	output logic [sbtr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// requests
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [sbtr_pkg::KIND_W-1:0]    kind,
	input  wire  [sbtr_pkg::COORD_W-1:0]   pos_x,
	input  wire  [sbtr_pkg::COORD_W-1:0]   pos_y,
	input  wire  [sbtr_pkg::CODE_W-1:0]    char_code,
	input  wire  [sbtr_pkg::COL_W-1:0]     pixel_colour,
	// row results
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [sbtr_pkg::COORD_W-1:0]   row_x,
	output logic [sbtr_pkg::COORD_W-1:0]   row_y,
	output logic [sbtr_pkg::MASK_W-1:0]    fg_mask,
	output logic [sbtr_pkg::SPAN_W-1:0]    span,
	output logic [sbtr_pkg::COL_W-1:0]     colour,
	output logic                           last
);

	logic [sbtr_pkg::SCALE_W-1:0] scale;
	logic [sbtr_pkg::COL_W-1:0]   fg_colour;
	logic [sbtr_pkg::COL_W-1:0]   match_colour;
	sbtr_pkg::cmd_t               cmd;
	sbtr_pkg::stat_t              stat;

	// register file: scale is kept raw, the datapath clamps it
	sbtr_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.scale        (scale),
		.fg_colour    (fg_colour),
		.match_colour (match_colour)
	);

	// sequencer: decodes requests and steps write and row phases
	sbtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.char_code (char_code),
		.stat      (stat),
		.cmd       (cmd)
	);

	// atlas memory, cursor, row expansion and output register
	sbtr_dp #(
		.GLYPH_W        (GLYPH_W),
		.GLYPH_H        (GLYPH_H),
		.GLYPHS_PER_ROW (GLYPHS_PER_ROW),
		.NUM_GLYPHS     (NUM_GLYPHS),
		.MAX_SCALE      (MAX_SCALE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.char_code    (char_code),
		.pixel_colour (pixel_colour),
		.scale        (scale),
		.fg_colour    (fg_colour),
		.match_colour (match_colour),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_x        (row_x),
		.row_y        (row_y),
		.fg_mask      (fg_mask),
		.span         (span),
		.colour       (colour),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== dv/scaled_bitmap_text_renderer_tb.sv =====
`timescale 1ns / 100ps

import sbtr_pkg::*;

localparam int ATLAS_W   = DEF_GLYPHS_PER_ROW * DEF_GLYPH_W;
localparam int ATLAS_H   = ((DEF_NUM_GLYPHS + DEF_GLYPHS_PER_ROW - 1) / DEF_GLYPHS_PER_ROW)
	* DEF_GLYPH_H;
localparam int ATLAS_PIX = ATLAS_W * ATLAS_H;

localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

typedef struct packed {
	logic [KIND_W-1:0]  kind;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;
	logic [CODE_W-1:0]  code;
	logic [COL_W-1:0]   pcol;
} req_t;

typedef struct packed {
	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;
	logic [MASK_W-1:0]  mask;
	logic [SPAN_W-1:0]  spn;
	logic [COL_W-1:0]   col;
	logic               fin;
} row_t;

// glyph row predictor plus the queue of rows still owed by the block
class text_row_scoreboard;
	bit                 atlas [ATLAS_PIX];
	logic [COORD_W-1:0] cur_x, cur_y, origin_x;
	logic [SCALE_W-1:0] scale;
	logic [COL_W-1:0]   fg, match;
	row_t               rows_due [$];
	int                 errors, requests, chars_drawn, rows_checked;

	function new();
		cur_x = '0;
		cur_y = '0;
		origin_x = '0;
		scale = SCALE_RST;
		fg = COL_RST;
		match = COL_RST;
	endfunction

	function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
		case (idx)
			REG_SCALE: scale = value[SCALE_W-1:0];
			REG_FG:    fg = value;
			REG_MATCH: match = value;
			default: ;
		endcase
	endfunction

	function void take_request(req_t rq);
		int s, rows, spn, gx, gy, ay, ax, idx;
		logic [MASK_W-1:0] m;
		row_t row;
		requests++;
		case (rq.kind)
			KIND_PIXEL: begin
				if (rq.px < ATLAS_W && rq.py < ATLAS_H)
					atlas[rq.py * ATLAS_W + rq.px] = (rq.pcol == match);
			end
			KIND_START: begin
				cur_x = rq.px;
				cur_y = rq.py;
				origin_x = rq.px;
			end
			KIND_CHAR: begin
				// clamp: 0 acts as 1, above max acts as max
				s = (scale == 0) ? 1 : (scale > DEF_MAX_SCALE) ? DEF_MAX_SCALE : int'(scale);
				rows = DEF_GLYPH_H * s;
				spn = DEF_GLYPH_W * s;
				if (rq.code == NEWLINE_CODE) begin
					cur_x = origin_x;
					cur_y = cur_y + 16'((3 * rows) / 2);
				end else begin
					chars_drawn++;
					gx = (rq.code % DEF_GLYPHS_PER_ROW) * DEF_GLYPH_W;
					gy = (rq.code / DEF_GLYPHS_PER_ROW) * DEF_GLYPH_H;
					for (int r = 0; r < rows; r++) begin
						m = '0;
						if (rq.code < DEF_NUM_GLYPHS) begin
							ay = gy + r / s;
							for (int i = 0; i < spn; i++) begin
								ax = gx + i / s;
								idx = ay * ATLAS_W + ax;
								if (idx < ATLAS_PIX && atlas[idx])
									m[i] = 1'b1;
							end
						end
						row.x = cur_x;
						row.y = cur_y + 16'(r);
						row.mask = m;
						row.spn = 7'(spn);
						row.col = fg;
						row.fin = (r == rows - 1);
						rows_due.push_back(row);
					end
					cur_x = cur_x + 16'(spn);
				end
			end
			default: ;
		endcase
	endfunction

	function void flag(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		if (errors <= 40)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endfunction

	function void check_row(row_t got);
		row_t want;
		if (rows_due.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t: unexpected row, expected none, got x=%0h y=%0h mask=%0h",
					$time, got.x, got.y, got.mask);
			return;
		end
		want = rows_due.pop_front();
		rows_checked++;
		if (got.x !== want.x)       flag("row_x", want.x, got.x);
		if (got.y !== want.y)       flag("row_y", want.y, got.y);
		if (got.mask !== want.mask) flag("fg_mask", want.mask, got.mask);
		if (got.spn !== want.spn)   flag("span", want.spn, got.spn);
		if (got.col !== want.col)   flag("colour", want.col, got.col);
		if (got.fin !== want.fin)   flag("last", want.fin, got.fin);
	endfunction
endclass

module scaled_bitmap_text_renderer_tb;

	// generous: every request a 64-row glyph with maximal stalls, several times over
	localparam int LIMIT = 1_500_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid, in_ready;
	logic [KIND_W-1:0]    kind;
	logic [COORD_W-1:0]   pos_x, pos_y;
	logic [CODE_W-1:0]    char_code;
	logic [COL_W-1:0]     pixel_colour;
	logic                 out_valid, out_ready;
	logic [COORD_W-1:0]   row_x, row_y;
	logic [MASK_W-1:0]    fg_mask;
	logic [SPAN_W-1:0]    span;
	logic [COL_W-1:0]     colour;
	logic                 last;

	text_row_scoreboard sb;
	int                 cycles = 0;
	bit                 calm = 1'b0;    // no idling on either side while set
	int                 loaded_codes [$];

	scaled_bitmap_text_renderer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.char_code    (char_code),
		.pixel_colour (pixel_colour),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_x        (row_x),
		.row_y        (row_y),
		.fg_mask      (fg_mask),
		.span         (span),
		.colour       (colour),
		.last         (last)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL scaled_bitmap_text_renderer");
			$finish;
		end
	end

	// every row taken by the receiver is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_row({row_x, row_y, fg_mask, span, colour, last});
	end

	// receiver: random stall before each row, none while calm
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 10);
			repeat (stall) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one request: optional gap with valid low, then hold until accepted.
	// valid is left high after acceptance so back-to-back requests need no dip.
	task automatic send(input req_t rq);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		kind = rq.kind;
		pos_x = rq.px;
		pos_y = rq.py;
		char_code = rq.code;
		pixel_colour = rq.pcol;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_request(rq);
	endtask

	// sender holds off until every owed row is out; atlas writes give no
	// result, so an extra wait covers one still in flight
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.rows_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// unused fields carry random bits so every input bit toggles
	function automatic req_t char_req(input logic [CODE_W-1:0] code);
		req_t rq;
		rq.kind = KIND_CHAR;
		rq.px = $urandom();
		rq.py = $urandom();
		rq.code = code;
		rq.pcol = $urandom();
		return rq;
	endfunction

	function automatic req_t pixel_req(input int x, input int y, input logic [COL_W-1:0] col);
		req_t rq;
		rq.kind = KIND_PIXEL;
		rq.px = 16'(x);
		rq.py = 16'(y);
		rq.code = $urandom();
		rq.pcol = col;
		return rq;
	endfunction

	function automatic req_t start_req(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		req_t rq;
		rq.kind = KIND_START;
		rq.px = x;
		rq.py = y;
		rq.code = $urandom();
		rq.pcol = $urandom();
		return rq;
	endfunction

	function automatic req_t noise_req();
		req_t rq;
		rq.kind = KIND_UNUSED;
		rq.px = $urandom();
		rq.py = $urandom();
		rq.code = $urandom();
		rq.pcol = $urandom();
		return rq;
	endfunction

	// pixel inside an already loaded glyph: keeps every render on written atlas
	function automatic req_t glyph_pixel_req();
		int code;
		code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
		return pixel_req((code % DEF_GLYPHS_PER_ROW) * DEF_GLYPH_W + $urandom_range(0, 7),
			(code / DEF_GLYPHS_PER_ROW) * DEF_GLYPH_H + $urandom_range(0, 7),
			$urandom_range(0, 1) ? sb.match : $urandom());
	endfunction

	function automatic req_t random_req();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			return char_req(7'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]));
		else if (pick < 10)
			return char_req(NEWLINE_CODE);
		else if (pick < 12)
			return start_req($urandom(), $urandom());
		else if (pick < 16)
			return glyph_pixel_req();
		else if (pick < 18)
			return pixel_req($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
		return noise_req();
	endfunction

	// mostly small scales to keep the run short; clamped values now and then
	function automatic logic [PDATA_W-1:0] pick_scale();
		int d;
		d = $urandom_range(0, 9);
		if (d < 5)  return $urandom_range(1, 3);
		if (d == 5) return 0;
		if (d == 6) return $urandom_range(4, 7);
		if (d == 7) return DEF_MAX_SCALE;
		return $urandom_range(DEF_MAX_SCALE + 1, 15);
	endfunction

	// all 64 pixels of a glyph cell, about half of them foreground
	task automatic load_glyph(input int code);
		int gx, gy;
		gx = (code % DEF_GLYPHS_PER_ROW) * DEF_GLYPH_W;
		gy = (code / DEF_GLYPHS_PER_ROW) * DEF_GLYPH_H;
		for (int y = 0; y < DEF_GLYPH_H; y++)
			for (int x = 0; x < DEF_GLYPH_W; x++)
				send(pixel_req(gx + x, gy + y, $urandom_range(0, 1) ? sb.match : $urandom()));
		loaded_codes.push_back(code);
	endtask

	initial begin : stimulus
		int third;
		logic [PDATA_W-1:0] fg_val, match_val;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_PIXEL;
		pos_x = '0;
		pos_y = '0;
		char_code = '0;
		pixel_colour = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// font load: glyph 0 under the reset match colour, glyph 127 with match
		// all zeros, one more glyph with a random match colour
		load_glyph(0);
		settle();
		write_reg(REG_MATCH, '0);
		load_glyph(127);
		do third = $urandom_range(1, 126); while (third == NEWLINE_CODE);
		settle();
		write_reg(REG_MATCH, $urandom());
		load_glyph(third);

		// directed: reset scale and colour, code zero, highest code
		send(char_req(0));
		send(char_req(127));
		send(char_req(7'(third)));
		send(char_req(NEWLINE_CODE));
		// cursor at the top corner: row x, row y and the newline all wrap
		send(start_req(16'hFFFF, 16'hFFFF));
		send(char_req(0));
		send(char_req(127));
		send(char_req(NEWLINE_CODE));
		send(noise_req());
		// writes just off the atlas are dropped
		send(pixel_req(ATLAS_W, 0, sb.match));
		send(pixel_req(0, ATLAS_H, sb.match));
		send(pixel_req(16'hFFFF, 16'hFFFF, sb.match));
		// overwrite corner pixels of loaded glyphs
		send(pixel_req(ATLAS_W - 1, ATLAS_H - 1, ~sb.match));
		send(pixel_req(0, 0, sb.match));
		send(start_req(16'h0000, 16'h8000));
		send(char_req(0));
		send(char_req(127));
		// largest scale, full 64-bit masks, black foreground
		settle();
		write_reg(REG_SCALE, DEF_MAX_SCALE);
		write_reg(REG_FG, '0);
		send(char_req(0));
		send(char_req(127));
		send(char_req(NEWLINE_CODE));
		// scale 0 acts as 1, 15 as the maximum
		settle();
		write_reg(REG_SCALE, 0);
		send(char_req(0));
		send(char_req(NEWLINE_CODE));
		settle();
		write_reg(REG_SCALE, 15);
		send(char_req(127));

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			settle();
			fg_val = (p == 0) ? COL_RST : $urandom();
			match_val = (p == 1) ? COL_RST : (p == 3) ? '0 : $urandom();
			write_reg(REG_SCALE, pick_scale());
			write_reg(REG_FG, fg_val);
			write_reg(REG_MATCH, match_val);
			calm = (p == 2);
			repeat (20) send(random_req());
		end
		calm = 1'b0;

		settle();
		repeat (12) @(posedge clk);

		$display("Covered %0d requests: %0d glyph cells loaded, %0d characters drawn, %0d rows checked.",
			sb.requests, loaded_codes.size(), sb.chars_drawn, sb.rows_checked);
		$display("Scales incl. 0 and above max, colour extremes, coordinate wrap, unused kind, off-atlas writes.");
		if (sb.errors == 0) begin
			$display("PASS scaled_bitmap_text_renderer");
		end else begin
			$display("FAIL scaled_bitmap_text_renderer");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sbtr_pkg.sv
hdl/sbtr_regs.sv
hdl/sbtr_ctrl.sv
hdl/sbtr_dp.sv
hdl/scaled_bitmap_text_renderer.sv
dv/scaled_bitmap_text_renderer_tb.sv
